// ===== src/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared widths, action codes, character codes and digit-to-ASCII mapping
// for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int VALUE_BITS = 32;
	localparam int WORD_BITS  = 32;

	// decimal digits needed for 2^WORD_BITS-1 (log10(2) ~ 0.30103)
	localparam int DEC_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
	localparam int BCD_BITS   = 4 * DEC_DIGITS;
	localparam int HEX_BITS   = 4 * HEX_DIGITS;
	localparam int DIG_BITS   = (BCD_BITS > HEX_BITS) ? BCD_BITS : HEX_BITS;
	localparam int MAX_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);
	localparam int SHIFT_BITS = $clog2(WORD_BITS + 1);

	typedef enum logic [1:0] {
		ACT_SDEC = 2'd0,
		ACT_UDEC = 2'd1,
		ACT_HEX  = 2'd2,
		ACT_BAD  = 2'd3
	} act_t;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_X     = 7'h78;
	localparam logic [6:0] CH_QUEST = 7'h3F;
	localparam logic [6:0] CH_LOW_A = 7'h61;

	// one load of the character emitter
	typedef struct packed {
		logic [DIG_BITS-1:0] digits;  // left aligned, most significant first
		logic [CNT_BITS-1:0] ndig;
		logic [1:0]          npre;
		logic [6:0]          pre0;
		logic [6:0]          pre1;
		logic                skip;    // suppress leading zeros
	} emit_job_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + 7'(d);
		end else begin
			c = CH_LOW_A + 7'(d - 4'd10);
		end
		return c;
	endfunction

endpackage

// ===== src/i2a_dabble.sv =====
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module i2a_dabble (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [i2a_pkg::WORD_BITS-1:0]  word,
	output logic                           busy,
	output logic [i2a_pkg::BCD_BITS-1:0]   bcd
);
	import i2a_pkg::*;

	logic [WORD_BITS-1:0]  bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [SHIFT_BITS-1:0] cnt_q;
	logic [BCD_BITS-1:0]   adj;

	// digits of 5 or more get 3 added before the doubling shift
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= SHIFT_BITS'(WORD_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= word;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[BCD_BITS-2:0], bin_q[WORD_BITS-1]};
			bin_q <= {bin_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;

endmodule

// ===== src/i2a_emit.sv =====
// ----------------------------------------------------------------------------
// i2a_emit
// Character emitter: prefix characters, then, unless stalled, one digit per
// cycle from a nibble shift register, leading zeros dropped, output registered.
// ----------------------------------------------------------------------------
module i2a_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  i2a_pkg::emit_job_t    job,
	output logic                  ready,
	output logic [6:0]            character,
	output logic                  last,
	output logic                  char_valid,
	input  logic                  char_stall
);
	import i2a_pkg::*;

	logic [DIG_BITS-1:0] dig_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [1:0]          pcnt_q;
	logic [6:0]          pre0_q;
	logic [6:0]          pre1_q;
	logic                skip_q;
	logic                vld_q;
	logic [6:0]          char_q;
	logic                last_q;

	logic [3:0]          top_dig;
	logic                adv;
	logic                lead_zero;
	logic                emit;
	logic [6:0]          emit_char;
	logic                emit_last;

	assign top_dig   = dig_q[DIG_BITS-1 -: 4];
	assign adv       = !vld_q || !char_stall;
	assign lead_zero = skip_q && (top_dig == 4'd0) && (cnt_q != CNT_BITS'(1));
	assign emit      = adv && ((pcnt_q != 2'd0) || ((cnt_q != '0) && !lead_zero));
	assign ready     = (pcnt_q == 2'd0) && (cnt_q == '0);

	always_comb begin
		if (pcnt_q != 2'd0) begin
			emit_char = pre0_q;
			emit_last = (pcnt_q == 2'd1) && (cnt_q == '0);
		end else begin
			emit_char = digit_char(top_dig);
			emit_last = (cnt_q == CNT_BITS'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pcnt_q <= 2'd0;
			skip_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (load) begin
				cnt_q  <= job.ndig;
				pcnt_q <= job.npre;
				skip_q <= job.skip;
			end else if (pcnt_q != 2'd0) begin
				if (adv) begin
					pcnt_q <= pcnt_q - 2'd1;
				end
			end else if (cnt_q != '0) begin
				if (lead_zero) begin
					cnt_q <= cnt_q - 1'b1;
				end else if (adv) begin
					cnt_q  <= cnt_q - 1'b1;
					skip_q <= 1'b0;
				end
			end
			if (emit) begin
				vld_q <= 1'b1;
			end else if (!char_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q  <= job.digits;
			pre0_q <= job.pre0;
			pre1_q <= job.pre1;
		end else if (pcnt_q != 2'd0) begin
			if (adv) begin
				pre0_q <= pre1_q;
			end
		end else if ((cnt_q != '0) && (lead_zero || adv)) begin
			dig_q <= {dig_q[DIG_BITS-5:0], 4'd0};
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign character  = char_q;
	assign last       = last_q;
	assign char_valid = vld_q;

endmodule

// ===== src/integer_to_ascii_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a word as signed decimal, unsigned decimal, 0x-prefixed hex or '?' for
// an undefined action, one ASCII character per output transaction, last flag on the final one.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  item     | item_valid, item_stall | value[31:0], action[1:0]
//  char     | char_valid, char_stall | character[6:0], last
//
//  Decimal: accept, then a bit-by-bit shift through the bit-serial BCD
//  converter, a check that the converter is done and a load, then every
//  digit including skipped leading zeros, after any sign character.
//  Hex: accept, load, 10 chars.
//  The next item is taken and converted while the previous one is emitted.
//  arst_n clears all control state; char_stall holds the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [i2a_pkg::VALUE_BITS-1:0]  value,
	input  logic [1:0]                      action,
	output logic                            char_valid,
	input  logic                            char_stall,
	output logic [6:0]                      character,
	output logic                            last
);
	import i2a_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t                          state_q;
	act_t                            act_q;
	logic                            neg_q;
	logic [WORD_BITS-1:0]            word_q;

	logic [WORD_BITS+VALUE_BITS-1:0] value_ext;
	logic [WORD_BITS-1:0]            word;
	logic [WORD_BITS-1:0]            mag;
	logic                            neg;
	act_t                            act_in;
	logic                            accept;
	logic                            conv_start;
	logic                            conv_busy;
	logic [BCD_BITS-1:0]             bcd;
	logic                            emit_ready;
	logic                            emit_load;
	emit_job_t                       job;

	assign value_ext  = {{WORD_BITS{1'b0}}, value};
	assign word       = value_ext[WORD_BITS-1:0];
	assign act_in     = act_t'(action);
	assign neg        = (act_in == ACT_SDEC) && word[WORD_BITS-1];
	assign mag        = neg ? (~word + 1'b1) : word;
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign conv_start = accept && ((act_in == ACT_SDEC) || (act_in == ACT_UDEC));
	assign emit_load  = (state_q == ST_LOAD) && emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (conv_start) begin
						state_q <= ST_CONV;
					end else if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_CONV: begin
					if (!conv_busy) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (emit_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= act_in;
			neg_q  <= neg;
			word_q <= word;
		end
	end

	always_comb begin
		job        = '0;
		job.pre0   = CH_QUEST;
		job.pre1   = CH_X;
		case (act_q)
			ACT_SDEC, ACT_UDEC: begin
				job.digits = DIG_BITS'(bcd) << (DIG_BITS - BCD_BITS);
				job.ndig   = CNT_BITS'(DEC_DIGITS);
				job.npre   = neg_q ? 2'd1 : 2'd0;
				job.pre0   = CH_MINUS;
				job.skip   = 1'b1;
			end
			ACT_HEX: begin
				job.digits = DIG_BITS'(HEX_BITS'(word_q)) << (DIG_BITS - HEX_BITS);
				job.ndig   = CNT_BITS'(HEX_DIGITS);
				job.npre   = 2'd2;
				job.pre0   = CH_ZERO;
				job.pre1   = CH_X;
			end
			default: begin
				job.npre   = 2'd1;
				job.pre0   = CH_QUEST;
			end
		endcase
	end

	i2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.word   (mag),
		.busy   (conv_busy),
		.bcd    (bcd)
	);

	i2a_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (emit_load),
		.job        (job),
		.ready      (emit_ready),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_stall (char_stall)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks integer_to_ascii_formatter_core: every accepted word is turned into
// its expected character run (signed decimal, unsigned decimal, 0x hex or the
// '?' for an undefined action), and each output transaction is compared in
// order against it. A directed table covers the extremes; random words follow
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
	import i2a_pkg::*;

	localparam int DIR_ROWS       = 20;
	localparam int PHASE_ITEMS    = 105;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [31:0] value;
		act_t        action;
		string       text;   // known answer, empty when the predictor decides
		bit          drain;  // hold this word back until all output is out
	} fmt_item_t;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} char_exp_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [31:0] value      = '0;
	logic [1:0]  action     = ACT_SDEC;
	logic        char_valid;
	logic        char_stall = 1'b0;
	logic [6:0]  character;
	logic        last;

	fmt_item_t   item_feed[$];
	char_exp_t   pending_chars[$];
	fmt_item_t   cur_item;
	fmt_item_t   directed_rows [DIR_ROWS];

	int          tx_idle_pct  = 0;
	int          rx_stall_pct = 0;
	bit          hold_start   = 1'b0;
	int          hold_left    = 0;
	int          err_count    = 0;
	int          idle_cycles  = 0;

	integer_to_ascii_formatter_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.action     (action),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.last       (last)
	);

	always begin
		#10 clk = 1'b0;
		#10 clk = 1'b1;
	end

	// text the block should print for one word
	function automatic string format_text(logic [31:0] v, act_t a);
		logic [31:0] mag;
		string       s;
		case (a)
			ACT_SDEC: begin
				mag = v[31] ? -v : v;
				s = $sformatf("%0d", mag);
				if (v[31]) begin
					s = {"-", s};
				end
			end
			ACT_UDEC: s = $sformatf("%0d", v);
			ACT_HEX:  s = $sformatf("0x%08h", v);
			default:  s = "?";
		endcase
		return s;
	endfunction

	task automatic queue_chars(string s);
		char_exp_t e;
		for (int i = 0; i < s.len(); i++) begin
			e.ch   = 7'(s[i]);
			e.last = (i == s.len() - 1);
			pending_chars.push_back(e);
		end
	endtask

	task automatic report_mismatch(string what);
		err_count++;
		if (err_count <= 10) begin
			$display("tb: %s", what);
		end
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		p = 32'd1;
		case ($urandom_range(5))
			0: return 32'($urandom_range(9));
			1: return 32'($urandom_range(99999));
			2: begin
				// straddle a power of ten
				repeat ($urandom_range(9)) p = p * 32'd10;
				return p + 32'($urandom_range(2)) - 32'd1;
			end
			3: return {1'b1, 31'($urandom)};
			4: return ~32'($urandom_range(999));
			default: return $urandom;
		endcase
	endfunction

	function automatic act_t pick_action();
		if ($urandom_range(15) == 0) begin
			return ACT_BAD;
		end
		return act_t'($urandom_range(2));
	endfunction

	task automatic add_random(int n);
		fmt_item_t it;
		for (int i = 0; i < n; i++) begin
			it.value  = pick_value();
			it.action = pick_action();
			it.text   = "";
			it.drain  = ($urandom_range(29) == 0);
			item_feed.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (item_feed.size() != 0 || item_valid || pending_chars.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				queue_chars(cur_item.text != "" ? cur_item.text :
				            format_text(cur_item.value, cur_item.action));
			end
			if (!item_valid || !item_stall) begin
				if (item_feed.size() != 0 &&
				    !(item_feed[0].drain && pending_chars.size() != 0) &&
				    $urandom_range(99) >= tx_idle_pct) begin
					cur_item = item_feed.pop_front();
					item_valid <= 1'b1;
					value      <= cur_item.value;
					action     <= cur_item.action;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		char_exp_t e;
		if (arst_n && char_valid && !char_stall) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %02h last %0b", character, last));
			end else begin
				e = pending_chars.pop_front();
				if (character !== e.ch || last !== e.last) begin
					report_mismatch($sformatf("char exp %02h last %0b, got %02h last %0b",
					                          e.ch, e.last, character, last));
				end
			end
		end
		if (hold_start) begin
			hold_left  = LONG_HOLD;
			hold_start = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			char_stall <= 1'b1;
		end else begin
			char_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (char_valid && !char_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		directed_rows = '{
			'{32'h0000_0000, ACT_SDEC, "0",           1'b0},
			'{32'h0000_0000, ACT_UDEC, "0",           1'b0},
			'{32'h0000_0000, ACT_HEX,  "0x00000000",  1'b0},
			'{32'hFFFF_FFFF, ACT_SDEC, "-1",          1'b0},
			'{32'hFFFF_FFFF, ACT_UDEC, "4294967295",  1'b0},
			'{32'hFFFF_FFFF, ACT_HEX,  "0xffffffff",  1'b0},
			'{32'h8000_0000, ACT_SDEC, "-2147483648", 1'b0},
			'{32'h8000_0000, ACT_UDEC, "2147483648",  1'b0},
			'{32'h7FFF_FFFF, ACT_SDEC, "2147483647",  1'b0},
			'{32'h7FFF_FFFF, ACT_HEX,  "0x7fffffff",  1'b0},
			'{32'h0000_0000, ACT_BAD,  "?",           1'b0},
			'{32'hFFFF_FFFF, ACT_BAD,  "?",           1'b0},
			'{32'd9,         ACT_UDEC, "9",           1'b0},
			'{32'd10,        ACT_UDEC, "10",          1'b0},
			'{32'd1000000000, ACT_SDEC, "",           1'b0},
			'{32'h89AB_CDEF, ACT_HEX,  "0x89abcdef",  1'b0},
			'{32'h0123_4567, ACT_HEX,  "",            1'b0},
			'{32'hFFFF_FFF6, ACT_SDEC, "-10",         1'b0},
			'{32'd999999999, ACT_UDEC, "",            1'b0},
			'{32'd1,         ACT_SDEC, "1",           1'b0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			item_feed.push_back(directed_rows[i]);
		end
		wait_drained();

		// no idling; the output side holds off for a long stretch so the block backs up
		add_random(PHASE_ITEMS);
		repeat (30) @(negedge clk);
		hold_start = 1'b1;
		wait_drained();

		tx_idle_pct = 51;
		add_random(1);
		item_feed[0].drain = 1'b1;
		add_random(PHASE_ITEMS - 1);
		wait_drained();

		tx_idle_pct  = 0;
		rx_stall_pct = 51;
		add_random(PHASE_ITEMS);
		wait_drained();

		tx_idle_pct  = 13;
		rx_stall_pct = 13;
		add_random(PHASE_ITEMS);
		wait_drained();

		rx_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
